// File: design/lmfs_pkg.sv
`default_nettype none

package lmfs_pkg;

    // stream widths, fixed by the field layout
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 1;
    localparam int DRIVE_W   = 6;
    localparam int M_TDATA_W = 16;

    // request kinds carried on the slave-side tuser
    typedef enum logic [S_TUSER_W-1:0] {
        CMD_BYTE = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    typedef logic [7:0] t_boot_line;

    // power-up picture, rows beyond the sixth stay dark
    localparam t_boot_line BOOT_IMAGE [8] = '{
        8'h1e, 8'h21, 8'h27, 8'h27, 8'h21, 8'h1e, 8'h00, 8'h00
    };

endpackage

`default_nettype wire

// File: design/led_matrix_frame_scanner.sv
// channel  | dir | signals                          | payload
// ---------+-----+----------------------------------+---------------------------------------
// s_axis   | in  | s_axis_tvalid/tready/tdata/tuser | tdata: rx_byte; tuser: cmd
// m_axis   | out | m_axis_tvalid/tready/tdata       | row_drive, column_drive, image_loaded
// cfg      | in  | i_cfg_we, i_cfg_wdata            | mirror_enable
//
// a new request can enter on each clock while s_axis_tready is high
// a scan tick yields one result in the next cycle from the output register
// a serial byte only updates the receive state and yields no result
// s_axis_tready drops only while a result sits in the output register and m_axis_tready is low
// i_rst_n is synchronous, active low; the boot picture is shown after reset, mirror mode is on
`default_nettype none

module led_matrix_frame_scanner #(
    parameter int GRID_SIZE = 6
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [lmfs_pkg::S_TDATA_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [lmfs_pkg::S_TUSER_W-1:0]  s_axis_tuser,   // [0] cmd
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [lmfs_pkg::M_TDATA_W-1:0]  m_axis_tdata    // [5:0] row_drive,
                                                            // [11:6] column_drive,
                                                            // [12] image_loaded, [15:13] zero
);
    import lmfs_pkg::*;

    localparam int IDX_W  = $clog2(GRID_SIZE);
    localparam int WIDE_W = (GRID_SIZE > DRIVE_W) ? GRID_SIZE : DRIVE_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GRID_SIZE - 1);

    typedef logic [GRID_SIZE-1:0] t_line;

    logic             r_mirror;
    logic [IDX_W-1:0] r_rx_pos;
    logic             r_rx_active;
    logic             r_pending;
    t_line            r_rx_rows [GRID_SIZE];
    t_line            r_disp    [GRID_SIZE];
    logic [IDX_W-1:0] r_row;
    logic [IDX_W-1:0] r_col;
    logic             r_out_valid;
    logic [DRIVE_W-1:0] r_row_drive;
    logic [DRIVE_W-1:0] r_col_drive;
    logic             r_loaded;

    logic             accept;
    logic             is_tick;
    t_line            rx_line;
    logic [IDX_W-1:0] n_row;
    logic [IDX_W-1:0] n_col;
    logic             n_load;
    t_line            n_disp [GRID_SIZE];
    t_line            row_bits;
    logic             pixel;
    t_line            row_line;
    t_line            col_line;
    logic [WIDE_W-1:0] row_wide;
    logic [WIDE_W-1:0] col_wide;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_tick       = (t_cmd'(s_axis_tuser) == CMD_TICK);
    assign rx_line       = s_axis_tdata[GRID_SIZE-1:0];

    // scan advances before it drives
    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_load = 1'b0;
        if (r_col == LAST_IDX) begin
            n_col = '0;
            if (r_row == LAST_IDX) begin
                n_row  = '0;
                n_load = r_pending;
            end else begin
                n_row = IDX_W'(r_row + 1'b1);
            end
        end else begin
            n_col = IDX_W'(r_col + 1'b1);
        end
    end

    // picture after a possible load; mirror flips row order and bit order
    always_comb begin
        for (int i = 0; i < GRID_SIZE; i++) begin
            n_disp[i] = r_disp[i];
            if (n_load) begin
                if (r_mirror) begin
                    for (int k = 0; k < GRID_SIZE; k++) begin
                        n_disp[i][GRID_SIZE-1-k] = r_rx_rows[GRID_SIZE-1-i][k];
                    end
                end else begin
                    n_disp[i] = r_rx_rows[i];
                end
            end
        end
    end

    // msb of a row is column 1
    always_comb begin
        row_bits = n_disp[n_row];
        pixel    = row_bits[LAST_IDX - n_col];
        row_line = ~(t_line'(1) << n_row);
        col_line = t_line'(pixel) << n_col;
        row_wide = WIDE_W'(row_line);
        col_wide = WIDE_W'(col_line);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirror    <= 1'b1;
            r_rx_pos    <= '0;
            r_rx_active <= 1'b0;
            r_pending   <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < GRID_SIZE; i++) begin
                r_rx_rows[i] <= '0;
                r_disp[i]    <= GRID_SIZE'(BOOT_IMAGE[i]);
            end
        end else begin
            if (i_cfg_we) begin
                r_mirror <= i_cfg_wdata;
            end

            if (accept && is_tick) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (accept) begin
                if (is_tick) begin
                    r_row <= n_row;
                    r_col <= n_col;
                    if (n_load) begin
                        r_disp    <= n_disp;
                        r_pending <= 1'b0;
                        for (int i = 0; i < GRID_SIZE; i++) begin
                            r_rx_rows[i] <= '0;
                        end
                    end
                end else if (!r_rx_active) begin
                    // only a zero byte opens a frame
                    if (s_axis_tdata == '0) begin
                        r_rx_active <= 1'b1;
                        r_rx_pos    <= '0;
                    end
                end else begin
                    r_rx_rows[r_rx_pos] <= rx_line;
                    if (r_rx_pos == LAST_IDX) begin
                        r_rx_pos    <= '0;
                        r_rx_active <= 1'b0;
                        r_pending   <= 1'b1;
                    end else begin
                        r_rx_pos <= IDX_W'(r_rx_pos + 1'b1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_tick) begin
            r_row_drive <= row_wide[DRIVE_W-1:0];
            r_col_drive <= col_wide[DRIVE_W-1:0];
            r_loaded    <= n_load;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_loaded, r_col_drive, r_row_drive};

endmodule

`default_nettype wire

// File: design/lmfs_chk.sv
`default_nettype none

module lmfs_chk (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            s_axis_tready,
    input  wire                            m_axis_tvalid,
    input  wire                            m_axis_tready,
    input  wire [lmfs_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import lmfs_pkg::*;

    localparam int LOADED_BIT = 2 * DRIVE_W;

    // a held result keeps its payload
    a_hold_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result payload changed while stalled");

    // at most one column lit per tick
    a_one_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $onehot0(m_axis_tdata[2*DRIVE_W-1:DRIVE_W]))
        else $error("more than one column driven");

    // a load happens only at scan wrap, so row 1 is driven
    a_load_row1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[LOADED_BIT] |-> !m_axis_tdata[0])
        else $error("image loaded away from the first row");

    // input side stalls only behind a waiting result
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled with no result waiting");

endmodule

bind led_matrix_frame_scanner lmfs_chk u_lmfs_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: tb/sv/tb_led_matrix_frame_scanner.sv
`default_nettype none

module tb_led_matrix_frame_scanner;
    import lmfs_pkg::*;

    localparam int GRID           = 6;
    localparam int WATCHDOG_LIMIT = 200;
    localparam int DRAIN_CYCLES   = 4;
    localparam logic [5:0] POWER_UP_IMAGE [GRID] = '{
        6'h1e, 6'h21, 6'h27, 6'h27, 6'h21, 6'h1e
    };

    // same bit order as m_axis_tdata[12:0]
    typedef struct packed {
        logic       image_loaded;
        logic [5:0] column_drive;
        logic [5:0] row_drive;
    } t_drive;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic                 i_cfg_wdata   = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;   // [7:0] rx_byte
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;   // [0] cmd
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;         // [5:0] row, [11:6] column, [12] loaded

    // scanner state as predicted
    logic       mirror_mode;
    logic [2:0] rx_count;
    logic       frame_open;
    logic       frame_ready;
    logic [5:0] rx_store [GRID];
    logic [5:0] shown [GRID];
    logic [2:0] row_pos;
    logic [2:0] col_pos;

    t_drive expected_drives [$];

    bit jitter_on = 1'b1;
    int mismatches;
    int quiet_cycles;
    int ticks_sent;
    int bytes_sent;
    int frames_started;
    int images_seen;

    led_matrix_frame_scanner dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic reset_scan_state();
        mirror_mode = 1'b1;
        rx_count    = '0;
        frame_open  = 1'b0;
        frame_ready = 1'b0;
        row_pos     = '0;
        col_pos     = '0;
        for (int i = 0; i < GRID; i++) begin
            rx_store[i] = '0;
            shown[i]    = POWER_UP_IMAGE[i];
        end
    endtask

    function automatic void predict_request(t_cmd cmd, logic [7:0] rx_byte);
        t_drive d;
        logic [5:0] line;
        d = '0;
        if (cmd == CMD_BYTE) begin
            if (!frame_open) begin
                // only a zero byte opens a frame
                if (rx_byte == 8'h00) begin
                    frame_open = 1'b1;
                    rx_count   = '0;
                end
            end else begin
                if (rx_count < GRID)
                    rx_store[rx_count] = rx_byte[5:0];
                rx_count = rx_count + 3'd1;
                if (rx_count >= GRID) begin
                    rx_count    = '0;
                    frame_open  = 1'b0;
                    frame_ready = 1'b1;
                end
            end
        end else begin
            if (col_pos >= GRID - 1) begin
                col_pos = '0;
                if (row_pos >= GRID - 1) begin
                    row_pos = '0;
                    if (frame_ready) begin
                        for (int i = 0; i < GRID; i++)
                            for (int k = 0; k < GRID; k++)
                                shown[i][k] = mirror_mode ? rx_store[GRID-1-i][GRID-1-k]
                                                          : rx_store[i][k];
                        for (int i = 0; i < GRID; i++)
                            rx_store[i] = '0;
                        frame_ready    = 1'b0;
                        d.image_loaded = 1'b1;
                    end
                end else begin
                    row_pos = row_pos + 3'd1;
                end
            end else begin
                col_pos = col_pos + 3'd1;
            end
            // column 1 sits in the top bit of a stored row
            line = shown[row_pos];
            d.row_drive = ~(6'b000001 << row_pos);
            d.column_drive[col_pos] = line[GRID - 1 - col_pos];
            expected_drives.push_back(d);
        end
    endfunction

    task automatic report_mismatch(string what, t_drive want, logic [M_TDATA_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: row exp %h got %h, column exp %h got %h, loaded exp %b got %b, pad %h",
                     what, want.row_drive, got[5:0], want.column_drive, got[11:6],
                     want.image_loaded, got[12], got[15:13]);
    endtask

    task automatic check_drive(logic [M_TDATA_W-1:0] got);
        t_drive want;
        if (got[12])
            images_seen++;
        if (expected_drives.size() == 0) begin
            want = 'x;
            report_mismatch("result with nothing expected", want, got);
        end else begin
            want = expected_drives.pop_front();
            if (got[12:0] !== want || got[15:13] !== 3'b000)
                report_mismatch("drive mismatch", want, got);
        end
    endtask

    // prediction, checking and the watchdog all run on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                predict_request(t_cmd'(s_axis_tuser), s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                check_drive(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("timeout after %0d quiet cycles", quiet_cycles);
                    $display("led_matrix_frame_scanner: mismatch");
                    $finish;
                end
            end
        end
    end

    // result side: random stall before each accepted result
    initial begin
        int stall;
        forever begin
            stall = jitter_on ? $urandom_range(10, 0) : 0;
            repeat (stall) begin
                @(negedge i_clk);
                m_axis_tready = 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && i_rst_n));
        end
    end

    task automatic send_request(t_cmd cmd, logic [7:0] rx_byte);
        int gap;
        gap = jitter_on ? $urandom_range(10, 0) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = rx_byte;
        do @(posedge i_clk); while (!s_axis_tready);
        if (cmd == CMD_TICK)
            ticks_sent++;
        else
            bytes_sent++;
    endtask

    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (expected_drives.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mirror(logic value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(posedge i_clk);
        mirror_mode = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // mixes scan ticks, well-formed frames with random rows and stray bytes
    task automatic random_traffic(int count, int tick_pct);
        int frame_left;
        int pick;
        logic [7:0] b;
        frame_left = 0;
        repeat (count) begin
            pick = $urandom_range(99, 0);
            if (pick < tick_pct) begin
                send_request(CMD_TICK, 8'($urandom));
            end else if (pick < tick_pct + 6) begin
                send_request(CMD_BYTE, 8'($urandom));
            end else if (pick < tick_pct + 8) begin
                // abandon the frame, the next one restarts with a sync
                frame_left = 0;
                send_request(CMD_BYTE, 8'($urandom_range(255, 1)));
            end else begin
                if (frame_left == 0) begin
                    b = 8'h00;
                    frame_left = GRID;
                    frames_started++;
                end else begin
                    b = ($urandom_range(7, 0) == 0) ? 8'h00 : 8'($urandom);
                    frame_left--;
                end
                send_request(CMD_BYTE, b);
            end
        end
    endtask

    task automatic test_boot_and_framing();
        // first tick lights row 1, column 2 of the boot picture
        send_request(CMD_TICK, 8'h00);
        send_request(CMD_TICK, 8'hff);
        // nonzero bytes outside a frame are dropped
        send_request(CMD_BYTE, 8'hff);
        send_request(CMD_BYTE, 8'h80);
        send_request(CMD_BYTE, 8'h01);
        send_request(CMD_BYTE, 8'h00);
        // a zero inside a frame is row data
        send_request(CMD_BYTE, 8'h00);
        send_request(CMD_BYTE, 8'hff);
        send_request(CMD_BYTE, 8'h2a);
        send_request(CMD_BYTE, 8'h15);
        send_request(CMD_BYTE, 8'hc1);
        send_request(CMD_BYTE, 8'h3f);
        frames_started++;
        send_request(CMD_TICK, 8'h00);
        // second frame while one is pending, left incomplete
        send_request(CMD_BYTE, 8'h00);
        send_request(CMD_BYTE, 8'h21);
        send_request(CMD_BYTE, 8'h7e);
        frames_started++;
        repeat (4) send_request(CMD_TICK, 8'h00);
        settle();
    endtask

    task automatic test_plain_orientation();
        write_mirror(1'b0);
        random_traffic(450, 55);
        settle();
    endtask

    task automatic test_mirrored_back_to_back();
        jitter_on = 1'b0;
        write_mirror(1'b1);
        random_traffic(400, 55);
        settle();
        jitter_on = 1'b1;
    endtask

    task automatic test_sparse_frames();
        write_mirror(1'b0);
        random_traffic(400, 85);
        settle();
    endtask

    task automatic test_random_orientation();
        write_mirror(1'($urandom_range(1, 0)));
        random_traffic(380, 60);
        settle();
    endtask

    initial begin
        reset_scan_state();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_boot_and_framing();
        test_plain_orientation();
        test_mirrored_back_to_back();
        test_sparse_frames();
        test_random_orientation();

        $display("sent %0d scan ticks and %0d serial bytes, %0d frames started",
                 ticks_sent, bytes_sent, frames_started);
        $display("saw %0d image loads across both orientations, with and without gaps",
                 images_seen);
        if (mismatches == 0 && expected_drives.size() == 0) begin
            $display("led_matrix_frame_scanner: match");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, expected_drives.size());
            $display("led_matrix_frame_scanner: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
